// ----- rtl/wspma_pkg.sv -----
// Shared types and constants of the weighted sky plane moment accumulator.
package wspma_pkg;

  localparam int VALUE_W = 24;
  localparam int VAR_W   = 24;
  localparam int COORD_W = 14;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W_BITS = 64;
  localparam int NUM_SUMS = 9;
  localparam int DIV_STEPS = 33;
  localparam int CFG_INDEX_W = 1;

  localparam logic [WEIGHT_W-1:0] W_ONE = 32'h0100_0000;
  localparam logic [WEIGHT_W-1:0] W_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONSTANT_WEIGHTING = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_ORDER        = 1'd1;

  // multiplier operand selections
  typedef logic [2:0] mul_op_t;
  localparam mul_op_t OP_NONE = 3'd0;
  localparam mul_op_t OP_CC   = 3'd1;
  localparam mul_op_t OP_CR   = 3'd2;
  localparam mul_op_t OP_RR   = 3'd3;
  localparam mul_op_t OP_FC   = 3'd4;
  localparam mul_op_t OP_FR   = 3'd5;
  localparam mul_op_t OP_LO   = 3'd6;
  localparam mul_op_t OP_HI   = 3'd7;

  // first-level product slots
  typedef logic [2:0] pre_idx_t;
  localparam pre_idx_t PRE_CC = 3'd0;
  localparam pre_idx_t PRE_CR = 3'd1;
  localparam pre_idx_t PRE_RR = 3'd2;
  localparam pre_idx_t PRE_FC = 3'd3;
  localparam pre_idx_t PRE_FR = 3'd4;

  // accumulator slots, in result order
  typedef logic [3:0] sum_idx_t;
  localparam sum_idx_t SUM_W  = 4'd0;
  localparam sum_idx_t SUM_F  = 4'd1;
  localparam sum_idx_t SUM_C  = 4'd2;
  localparam sum_idx_t SUM_R  = 4'd3;
  localparam sum_idx_t SUM_CC = 4'd4;
  localparam sum_idx_t SUM_CR = 4'd5;
  localparam sum_idx_t SUM_RR = 4'd6;
  localparam sum_idx_t SUM_FC = 4'd7;
  localparam sum_idx_t SUM_FR = 4'd8;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     w_set;
    logic     unit_weight;
    mul_op_t  mul_op;
    logic     pre_wr;
    pre_idx_t pre_idx;
    logic     cap_lo;
    logic     mag;
    logic     clip;
    logic     acc;
    sum_idx_t term;
    logic     emit;
    logic     order;
  } dp_cmd_t;

endpackage

// ----- rtl/wspma_dp.sv -----
// Datapath: pixel latch, reciprocal divider, shared multiplier and accumulators.
module wspma_dp import wspma_pkg::*; #(
  parameter int COORD_LIMIT = 16384
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  input  logic signed [VALUE_W-1:0]   pixel_value,
  input  logic        [VAR_W-1:0]     pixel_variance,
  input  logic        [COORD_W-1:0]   column,
  input  logic        [COORD_W-1:0]   row,
  output logic        [62:0]          weight_sum,
  output logic signed [63:0]          flux_sum,
  output logic signed [63:0]          col_sum,
  output logic signed [63:0]          row_sum,
  output logic signed [63:0]          col_sq_sum,
  output logic signed [63:0]          col_row_sum,
  output logic signed [63:0]          row_sq_sum,
  output logic signed [63:0]          flux_col_sum,
  output logic signed [63:0]          flux_row_sum,
  output logic                        saturated
);

  localparam logic [16:0] CoordMax = 17'(COORD_LIMIT - 1);

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    if ({3'b000, c} > CoordMax) return CoordMax[COORD_W-1:0];
    return c;
  endfunction

  logic [VALUE_W-1:0]  fmag;
  logic                neg;
  logic [COORD_W-1:0]  col_r;
  logic [COORD_W-1:0]  row_r;
  logic [VAR_W-1:0]    var_r;
  logic [32:0]         div_n;
  logic [VAR_W-1:0]    div_rem;
  logic [32:0]         div_q;
  logic [VAR_W:0]      div_t;
  logic [WEIGHT_W-1:0] w;
  logic [27:0]         cc, cr, rr;
  logic [37:0]         fc, fr;
  logic [23:0]         mul_a;
  logic [31:0]         mul_b;
  logic [55:0]         mul_p;
  logic [55:0]         p_lo;
  logic [71:0]         mag;
  logic signed [63:0]  term;
  logic                term_sat;
  logic [37:0]         a_k;
  logic                neg_k;
  logic signed [63:0]  sums [NUM_SUMS];
  logic                ovf;
  logic signed [64:0]  acc_s;
  logic                acc_ovf;
  logic signed [63:0]  acc_v;

  // operand of the selected term
  always_comb begin
    unique case (cmd.term)
      SUM_W:   a_k = 38'd1;
      SUM_F:   a_k = {14'b0, fmag};
      SUM_C:   a_k = {24'b0, col_r};
      SUM_R:   a_k = {24'b0, row_r};
      SUM_CC:  a_k = {10'b0, cc};
      SUM_CR:  a_k = {10'b0, cr};
      SUM_RR:  a_k = {10'b0, rr};
      SUM_FC:  a_k = fc;
      SUM_FR:  a_k = fr;
      default: a_k = '0;
    endcase
    neg_k = neg && (cmd.term == SUM_F || cmd.term == SUM_FC || cmd.term == SUM_FR);
  end

  always_comb begin
    unique case (cmd.mul_op)
      OP_CC:   begin mul_a = {10'b0, col_r}; mul_b = {18'b0, col_r}; end
      OP_CR:   begin mul_a = {10'b0, col_r}; mul_b = {18'b0, row_r}; end
      OP_RR:   begin mul_a = {10'b0, row_r}; mul_b = {18'b0, row_r}; end
      OP_FC:   begin mul_a = fmag;           mul_b = {18'b0, col_r}; end
      OP_FR:   begin mul_a = fmag;           mul_b = {18'b0, row_r}; end
      OP_LO:   begin mul_a = a_k[23:0];      mul_b = w;              end
      OP_HI:   begin mul_a = {10'b0, a_k[37:24]}; mul_b = w;         end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  assign div_t = {div_rem, div_n[32]};

  always_comb begin
    acc_s   = {sums[cmd.term][63], sums[cmd.term]} + {term[63], term};
    acc_ovf = acc_s[64] != acc_s[63];
    if (acc_ovf) acc_v = acc_s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    else         acc_v = acc_s[63:0];
  end

  // payload, divider and product registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= pixel_value[VALUE_W-1];
      fmag    <= pixel_value[VALUE_W-1] ? (~pixel_value + 24'd1) : pixel_value;
      col_r   <= clamp_coord(column);
      row_r   <= clamp_coord(row);
      var_r   <= pixel_variance;
      div_n   <= 33'h1_0000_0000 + {10'b0, pixel_variance[VAR_W-1:1]};
      div_rem <= '0;
      div_q   <= '0;
    end
    if (cmd.div_step) begin
      div_n <= {div_n[31:0], 1'b0};
      if (div_t >= {1'b0, var_r}) begin
        div_rem <= VAR_W'(div_t - {1'b0, var_r});
        div_q   <= {div_q[31:0], 1'b1};
      end else begin
        div_rem <= div_t[VAR_W-1:0];
        div_q   <= {div_q[31:0], 1'b0};
      end
    end
    if (cmd.w_set) begin
      if (cmd.unit_weight)   w <= W_ONE;
      else if (var_r <= 24'd1) w <= W_MAX;
      else                   w <= div_q[31:0];
    end
    mul_p <= mul_a * mul_b;
    if (cmd.pre_wr) begin
      unique case (cmd.pre_idx)
        PRE_CC:  cc <= mul_p[27:0];
        PRE_CR:  cr <= mul_p[27:0];
        PRE_RR:  rr <= mul_p[27:0];
        PRE_FC:  fc <= mul_p[37:0];
        PRE_FR:  fr <= mul_p[37:0];
        default: ;
      endcase
    end
    if (cmd.cap_lo) p_lo <= mul_p;
    if (cmd.mag) mag <= {16'b0, p_lo} + {mul_p[47:0], 24'b0};
    if (cmd.clip) begin
      if (neg_k) begin
        if (mag[71:64] != 8'd0 || (mag[63] && mag[62:0] != 63'd0)) begin
          term     <= {1'b1, 63'b0};
          term_sat <= 1'b1;
        end else begin
          term     <= -mag[63:0];
          term_sat <= 1'b0;
        end
      end else if (mag[71:63] != 9'd0) begin
        term     <= {1'b0, {63{1'b1}}};
        term_sat <= 1'b1;
      end else begin
        term     <= mag[63:0];
        term_sat <= 1'b0;
      end
    end
    if (cmd.emit) begin
      weight_sum   <= sums[SUM_W][62:0];
      flux_sum     <= sums[SUM_F];
      col_sum      <= cmd.order ? sums[SUM_C]  : '0;
      row_sum      <= cmd.order ? sums[SUM_R]  : '0;
      col_sq_sum   <= cmd.order ? sums[SUM_CC] : '0;
      col_row_sum  <= cmd.order ? sums[SUM_CR] : '0;
      row_sq_sum   <= cmd.order ? sums[SUM_RR] : '0;
      flux_col_sum <= cmd.order ? sums[SUM_FC] : '0;
      flux_row_sum <= cmd.order ? sums[SUM_FR] : '0;
      saturated    <= ovf;
    end
  end

  // accumulators and the saturation flag
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      for (int i = 0; i < NUM_SUMS; i++) sums[i] <= '0;
      ovf <= 1'b0;
    end else if (cmd.acc) begin
      sums[cmd.term] <= acc_v;
      ovf <= ovf | term_sat | acc_ovf;
    end
  end

endmodule

// ----- rtl/wspma_ctrl.sv -----
// Controller: configuration registers, pixel sequencing and result handshake.
module wspma_ctrl import wspma_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic                   excluded,
  input  logic                   frame_end,
  output logic                   result_valid,
  input  logic                   result_stall,
  output dp_cmd_t                cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_WSET  = 4'd2;
  localparam logic [3:0] S_PMUL  = 4'd3;
  localparam logic [3:0] S_PWR   = 4'd4;
  localparam logic [3:0] S_TLO   = 4'd5;
  localparam logic [3:0] S_THI   = 4'd6;
  localparam logic [3:0] S_TMAG  = 4'd7;
  localparam logic [3:0] S_TCLIP = 4'd8;
  localparam logic [3:0] S_TACC  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [5:0] DivLast = 6'(DIV_STEPS - 1);

  logic [3:0] state, state_next;
  logic [5:0] div_cnt, div_cnt_next;
  pre_idx_t   pidx, pidx_next;
  sum_idx_t   term, term_next;
  logic       px_last;
  logic       cw, order;

  assign pixel_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    div_cnt_next    = div_cnt;
    pidx_next       = pidx;
    term_next       = term;
    cmd             = '0;
    cmd.unit_weight = cw;
    cmd.order       = order;
    cmd.term        = term;
    cmd.pre_idx     = pidx;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          if (excluded)  state_next = frame_end ? S_EMIT : S_IDLE;
          else if (cw)   state_next = S_WSET;
          else           state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 6'd1;
        if (div_cnt == DivLast) state_next = S_WSET;
      end
      S_WSET: begin
        cmd.w_set  = 1'b1;
        pidx_next  = PRE_CC;
        term_next  = SUM_W;
        state_next = order ? S_PMUL : S_TLO;
      end
      S_PMUL: begin
        unique case (pidx)
          PRE_CC:  cmd.mul_op = OP_CC;
          PRE_CR:  cmd.mul_op = OP_CR;
          PRE_RR:  cmd.mul_op = OP_RR;
          PRE_FC:  cmd.mul_op = OP_FC;
          PRE_FR:  cmd.mul_op = OP_FR;
          default: cmd.mul_op = OP_NONE;
        endcase
        state_next = S_PWR;
      end
      S_PWR: begin
        cmd.pre_wr = 1'b1;
        if (pidx == PRE_FR) begin
          state_next = S_TLO;
        end else begin
          pidx_next  = pidx + 3'd1;
          state_next = S_PMUL;
        end
      end
      S_TLO: begin
        cmd.mul_op = OP_LO;
        state_next = S_THI;
      end
      S_THI: begin
        cmd.mul_op = OP_HI;
        cmd.cap_lo = 1'b1;
        state_next = S_TMAG;
      end
      S_TMAG: begin
        cmd.mag    = 1'b1;
        state_next = S_TCLIP;
      end
      S_TCLIP: begin
        cmd.clip   = 1'b1;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.acc = 1'b1;
        if (term == (order ? SUM_FR : SUM_F)) begin
          state_next = px_last ? S_EMIT : S_IDLE;
        end else begin
          term_next  = term + 4'd1;
          state_next = S_TLO;
        end
      end
      S_EMIT: begin
        if (!result_valid || !result_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_cnt      <= '0;
      pidx         <= PRE_CC;
      term         <= SUM_W;
      px_last      <= 1'b0;
      result_valid <= 1'b0;
      cw           <= 1'b0;
      order        <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      pidx    <= pidx_next;
      term    <= term_next;
      if (cmd.load) px_last <= frame_end;
      if (cmd.emit)           result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_CONSTANT_WEIGHTING) cw <= cfg_data;
        if (cfg_index == REG_PLANE_ORDER)        order <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/weighted_sky_plane_moment_accumulator_unit.sv -----
// Top level of the weighted sky plane moment accumulator.
// Accumulates the weighted normal-equation sums of a sky plane fit, nine in
// plane order 1 and two in order 0, over a pixel stream and hands them out as
// one result transfer on each frame_end pixel, then clears them. Pixels are
// taken one at a time. An excluded pixel adds nothing to the sums. A kept
// pixel first passes the reciprocal divider (one quotient bit a cycle) with
// inverse variance weighting, which constant weighting skips; in plane order
// 1 it then forms five coordinate and flux products through the shared 24x32
// multiplier, which order 0 skips; then each sum updated takes two multiplier
// passes, a combine, a clip and a saturating add; on a frame_end pixel the
// result is issued last. A finished result waits in the output register
// while the next pixels are taken; only a second frame_end arriving before
// the first result has been transferred holds the block. The user must write
// configuration only while idle (the block does not enforce this); it then
// applies from the next pixel. Coordinates above COORD_LIMIT-1 are clamped.
module weighted_sky_plane_moment_accumulator_unit import wspma_pkg::*; #(
  parameter int COORD_LIMIT = 16384
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic                      cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic signed [VALUE_W-1:0] pixel_value,
  input  logic        [VAR_W-1:0]   pixel_variance,
  input  logic                      excluded,
  input  logic        [COORD_W-1:0] column,
  input  logic        [COORD_W-1:0] row,
  input  logic                      frame_end,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic        [62:0]        weight_sum,
  output logic signed [63:0]        flux_sum,
  output logic signed [63:0]        col_sum,
  output logic signed [63:0]        row_sum,
  output logic signed [63:0]        col_sq_sum,
  output logic signed [63:0]        col_row_sum,
  output logic signed [63:0]        row_sq_sum,
  output logic signed [63:0]        flux_col_sum,
  output logic signed [63:0]        flux_row_sum,
  output logic                      saturated
);

  dp_cmd_t cmd;

  // sequencing, configuration and the result handshake
  wspma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .excluded     (excluded),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // arithmetic: divider, multiplier, clip and saturating accumulators
  wspma_dp #(
    .COORD_LIMIT (COORD_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .pixel_value    (pixel_value),
    .pixel_variance (pixel_variance),
    .column         (column),
    .row            (row),
    .weight_sum     (weight_sum),
    .flux_sum       (flux_sum),
    .col_sum        (col_sum),
    .row_sum        (row_sum),
    .col_sq_sum     (col_sq_sum),
    .col_row_sum    (col_row_sum),
    .row_sq_sum     (row_sq_sum),
    .flux_col_sum   (flux_col_sum),
    .flux_row_sum   (flux_row_sum),
    .saturated      (saturated)
  );

endmodule

// ----- rtl/wspma_chk.sv -----
// Port-level checker for the accumulator, bound to the top level.
module wspma_chk import wspma_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_stall,
  input logic                      excluded,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic        [62:0]        weight_sum,
  input logic signed [63:0]        flux_sum,
  input logic signed [63:0]        col_sum,
  input logic                      saturated
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(weight_sum) &&
    $stable(flux_sum) && $stable(saturated))
    else $error("stalled result changed");

  // a kept pixel holds off the next pixel in the cycle after it is taken
  a_kept_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !excluded |=> pixel_stall)
    else $error("kept pixel did not hold the input");

  // a result is issued only from a busy state
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_stall))
    else $error("result issued while idle");

  // every kept pixel has nonzero weight, so an empty frame has empty sums
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && weight_sum == 63'd0 |-> flux_sum == 64'sd0 &&
    col_sum == 64'sd0 && !saturated)
    else $error("nonzero sums with zero weight");

endmodule

bind weighted_sky_plane_moment_accumulator_unit wspma_chk u_chk (.*);
